[design/wrm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed rate meter package
// Shared field widths, request codes and the fixed rate scale.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned WIN_W  = 32;
  localparam int unsigned CH_W   = 2;

  // Events per second in 48.16 fixed point: 1000 * 65536.
  localparam logic [31:0] RATE_SCALE = 32'd65536000;

  typedef enum logic {
    REQ_PUSH  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

endpackage : wrm_pkg
`default_nettype wire

[design/wrm_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed rate meter channels
// Request and result interfaces with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wrm_req_if
  import wrm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [CH_W-1:0]  channel;
  logic [VAL_W-1:0] sample_count;
  logic [VAL_W-1:0] sample_time;
  logic [VAL_W-1:0] now_time;
  logic [WIN_W-1:0] window_ms;

  modport source (output valid, req_type, channel, sample_count, sample_time,
                  now_time, window_ms, input ready);
  modport sink (input valid, req_type, channel, sample_count, sample_time,
                now_time, window_ms, output ready);
endinterface : wrm_req_if

interface wrm_res_if
  import wrm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             rate_valid;
  logic [VAL_W-1:0] rate;

  modport source (output valid, rate_valid, rate, input ready);
  modport sink (input valid, rate_valid, rate, output ready);
endinterface : wrm_res_if
`default_nettype wire

[design/wrm_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed rate meter divider
// Scales a count delta by the rate scale and divides it by a time delta,
// one quotient bit per cycle, saturating when the quotient overflows.
// ----------------------------------------------------------------------------
module wrm_div
  import wrm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] cnt,
  input  wire logic [VAL_W-1:0] den,
  output logic                  done,
  output logic [VAL_W-1:0]      quo
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_CHK  = 4'b0100,
    D_RUN  = 4'b1000
  } dstate_t;

  dstate_t          state;
  logic [VAL_W-1:0] d;
  logic [VAL_W-1:0] c;
  logic [VAL_W-1:0] plo;
  logic [VAL_W-1:0] phi;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] lo;
  logic [6:0]       bits;
  logic [VAL_W:0]   shifted;
  logic [VAL_W:0]   trial;
  logic [VAL_W-1:0] lo_sum;
  logic [VAL_W-1:0] hi_sum;

  // Combine the two partial products into a 128-bit product.
  assign lo_sum = plo + {phi[31:0], 32'd0};
  assign hi_sum = {32'd0, phi[63:32]} + {63'd0, (lo_sum < plo)};

  // One restoring step of the long division.
  assign shifted = {rem, lo[VAL_W-1]};
  assign trial   = shifted - {1'b0, d};

  // Sequencer: two partial products, an overflow check that saturates on overflow, else 64 steps.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            c     <= cnt;
            d     <= den;
            plo   <= {32'd0, cnt[31:0]} * {32'd0, RATE_SCALE};
            state <= D_MUL;
          end
        end
        D_MUL: begin
          phi   <= {32'd0, c[63:32]} * {32'd0, RATE_SCALE};
          state <= D_CHK;
        end
        D_CHK: begin
          rem  <= hi_sum;
          lo   <= lo_sum;
          bits <= 7'd64;
          if (hi_sum >= d) begin
            quo   <= '1;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            quo   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          lo <= {lo[VAL_W-2:0], 1'b0};
          if (!trial[VAL_W]) begin
            rem <= trial[VAL_W-1:0];
            quo <= {quo[VAL_W-2:0], 1'b1};
          end else begin
            rem <= shifted[VAL_W-1:0];
            quo <= {quo[VAL_W-2:0], 1'b0};
          end
          bits <= bits - 7'd1;
          if (bits == 7'd1) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A result only follows the overflow check or a running division.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == D_RUN || $past(state) == D_CHK))
    else $error("divider done without work");
  // Start is only given while idle.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == D_IDLE)
    else $error("divider started while busy");
  // Step count stays in range while running.
  a_bits: assert property (@(posedge clk) disable iff (rst)
    state == D_RUN |-> (bits != 7'd0 && bits <= 7'd64))
    else $error("divider step count out of range");
`endif

endmodule : wrm_div
`default_nettype wire

[design/windowed_rate_meter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed rate meter
// Per-channel rings of (count, time) samples; queries give a windowed rate.
//
// Channel  Role    Payload
// req      sink    req_type, channel, sample_count, sample_time, now_time,
//                  window_ms
// res      source  rate_valid, rate (one per query)
//
// After reset, a clearing pass writes zero to every ring slot, one slot a
// cycle, with req.ready low.
// A query reads slots back from the newest through the store's registered read
// port, up to RING_DEPTH-1 slots, then runs the shared divider when the walk
// gave a usable span.
// The block takes one request at a time; a result waits in the output
// register while res.ready is low.
// ----------------------------------------------------------------------------
module windowed_rate_meter
  import wrm_pkg::*;
#(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned RING_DEPTH = 1024
)(
  input wire logic clk,
  input wire logic rst,
  wrm_req_if.sink  req,
  wrm_res_if.source res
);

  localparam int unsigned RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DEP = CHANNELS * RING_DEPTH;
  localparam int unsigned AW  = (DEP > 1) ? $clog2(DEP) : 1;
  localparam logic [RW-1:0] LAST_SLOT = RW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEP - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_PUSH  = 8'b00000100,
    S_READ  = 8'b00001000,
    S_EVAL  = 8'b00010000,
    S_DSTRT = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  count_store [DEP];
  logic [VAL_W-1:0]  time_store  [DEP];
  logic [RW-1:0]     ring_head   [CHANNELS];
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     ch;
  logic [VAL_W-1:0]  p_count;
  logic [VAL_W-1:0]  p_time;
  logic [VAL_W-1:0]  now;
  logic [WIN_W-1:0]  window;
  logic [RW-1:0]     idx;
  logic [RW-1:0]     steps;
  logic [VAL_W-1:0]  rd_count;
  logic [VAL_W-1:0]  rd_time;
  logic [VAL_W-1:0]  newest_t;
  logic [VAL_W-1:0]  newest_c;
  logic [VAL_W-1:0]  oldest_t;
  logic [VAL_W-1:0]  oldest_c;
  logic              full;
  logic              div_start;
  logic              div_done;
  logic [VAL_W-1:0]  div_quo;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_count;
  logic [VAL_W-1:0]  wr_time;
  logic [AW-1:0]     rd_addr;
  logic [RW-1:0]     idx_prev;
  logic [VAL_W-1:0]  age;
  logic              out_valid;
  logic              out_rate_valid;
  logic [VAL_W-1:0]  out_rate;

  assign req.ready      = (state == S_IDLE) && !out_valid;
  assign res.valid      = out_valid;
  assign res.rate_valid = out_rate_valid;
  assign res.rate       = out_rate;

  // Store addressing: channel-major rows of RING_DEPTH slots.
  assign wr_addr  = (state == S_CLEAR) ? clr_addr
                  : AW'(ch * RING_DEPTH + ring_head[ch]);
  assign wr_en    = (state == S_CLEAR) || (state == S_PUSH);
  assign wr_count = (state == S_CLEAR) ? '0 : p_count;
  assign wr_time  = (state == S_CLEAR) ? '0 : p_time;
  assign idx_prev = (idx == '0) ? LAST_SLOT : idx - RW'(1);
  assign rd_addr  = AW'(ch * RING_DEPTH + idx_prev);
  assign age      = now - rd_time;

  // Sample memories with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_store[wr_addr] <= wr_count;
      time_store[wr_addr]  <= wr_time;
    end
    rd_count <= count_store[rd_addr];
    rd_time  <= time_store[rd_addr];
  end

  // The divider only starts when the walk produced a usable span.
  assign div_start = (state == S_DSTRT) && full && (oldest_t != '0)
                     && (newest_t != oldest_t);

  wrm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .cnt   (newest_c - oldest_c),
    .den   (newest_t - oldest_t),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer: clear, push, walk back through the ring, divide, respond.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        ring_head[k] <= '0;
      end
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            ch      <= CW'(req.channel);
            p_count <= req.sample_count;
            p_time  <= req.sample_time;
            now     <= req.now_time;
            window  <= req.window_ms;
            if (32'(req.channel) >= CHANNELS) begin
              if (req.req_type == REQ_QUERY) begin
                out_valid      <= 1'b1;
                out_rate_valid <= 1'b0;
                out_rate       <= '0;
              end
            end else if (req.req_type == REQ_PUSH) begin
              state <= S_PUSH;
            end else begin
              idx      <= ring_head[CW'(req.channel)];
              steps    <= LAST_SLOT;
              newest_t <= '0;
              newest_c <= '0;
              oldest_t <= '0;
              oldest_c <= '0;
              full     <= 1'b0;
              state    <= (RING_DEPTH > 1) ? S_READ : S_EVAL;
            end
          end
        end
        S_PUSH: begin
          ring_head[ch] <= (ring_head[ch] == LAST_SLOT) ? '0
                         : ring_head[ch] + RW'(1);
          state <= S_IDLE;
        end
        S_READ: begin
          // Read address is issued this cycle; data checked next cycle.
          idx   <= idx_prev;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (steps == '0 || rd_time == '0) begin
            state <= S_DSTRT;
          end else begin
            if (newest_t == '0) begin
              newest_t <= rd_time;
              newest_c <= rd_count;
            end
            if (age > {32'd0, window}) begin
              full  <= 1'b1;
              state <= S_DSTRT;
            end else begin
              oldest_t <= rd_time;
              oldest_c <= rd_count;
              steps    <= steps - RW'(1);
              state    <= (steps == RW'(1)) ? S_DSTRT : S_READ;
            end
          end
        end
        S_DSTRT: begin
          if (!full || oldest_t == '0 || newest_t == oldest_t) begin
            out_valid      <= 1'b1;
            out_rate_valid <= 1'b0;
            out_rate       <= '0;
            state          <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_valid      <= 1'b1;
            out_rate_valid <= 1'b1;
            out_rate       <= div_quo;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No request is taken during the clearing pass.
  a_no_req_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready)
    else $error("request ready during clear");
  // A valid rate only comes out of the divider.
  a_rate_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && out_rate_valid |-> $past(state) == S_DIV)
    else $error("valid rate without division");
  // An invalid result always carries a zero rate.
  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rate_valid |-> out_rate == '0)
    else $error("invalid result with nonzero rate");
  // The divider starts only from the query path.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV || state == S_OUT)
    else $error("divider started off the query path");
`endif

endmodule : windowed_rate_meter
`default_nettype wire

[tb/windowed_rate_meter_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed rate meter testbench
// Drives push and query requests on random channels with random idling on
// both sides, predicts every query's rate from a local copy of the sample
// rings, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module windowed_rate_meter_tb;
  import wrm_pkg::*;

  localparam int unsigned NCH   = 4;
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned N_RANDOM = 520;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct {
    req_type_t        kind;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] cnt;
    logic [VAL_W-1:0] ts;
    logic [VAL_W-1:0] now;
    logic [WIN_W-1:0] win;
  } request_t;

  typedef struct {
    logic             ok;
    logic [VAL_W-1:0] rate;
  } rate_t;

  // Directed row: the request plus an optional hand-typed expectation.
  typedef struct {
    request_t rq;
    logic     typed;
    rate_t    want;
  } row_t;

  logic clk;
  logic rst;
  wrm_req_if req_ch ();
  wrm_res_if res_ch ();

  windowed_rate_meter #(.CHANNELS(NCH), .RING_DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .res (res_ch.source)
  );

  // Local copy of the sample rings.
  logic [VAL_W-1:0] count_ring [NCH][DEPTH];
  logic [VAL_W-1:0] time_ring  [NCH][DEPTH];
  int unsigned      head_pos   [NCH];

  rate_t pending_rates [$];
  int unsigned fail_count;
  int unsigned n_push, n_query, n_valid, n_checked;
  longint unsigned cycle_count;
  bit quiet_side;

  // Exact floor(delta * 65536000 / span), saturating to 64 bits.
  function automatic logic [VAL_W-1:0] scale_rate(logic [VAL_W-1:0] delta,
                                                  logic [VAL_W-1:0] span);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, delta} * {96'd0, RATE_SCALE};
    quo  = prod / {64'd0, span};
    if (quo[127:64] != 0) return '1;
    return quo[63:0];
  endfunction

  // Walk back from the newest sample and form the windowed rate.
  function automatic rate_t window_rate(int unsigned ch, logic [VAL_W-1:0] now,
                                        logic [WIN_W-1:0] win);
    rate_t r;
    logic [VAL_W-1:0] nt, nc, ot, oc, t;
    bit past_window;
    int unsigned idx;
    r.ok = 1'b0;
    r.rate = '0;
    nt = 0; nc = 0; ot = 0; oc = 0;
    past_window = 0;
    for (int unsigned i = 1; i < DEPTH; i++) begin
      idx = (head_pos[ch] + DEPTH - i) % DEPTH;
      t = time_ring[ch][idx];
      if (t == 0) break;
      if (nt == 0) begin
        nt = t;
        nc = count_ring[ch][idx];
      end
      if (now - t > {32'd0, win}) begin
        past_window = 1;
        break;
      end
      ot = t;
      oc = count_ring[ch][idx];
    end
    if (!past_window || ot == 0 || nt == 0 || nt - ot == 0) return r;
    r.ok = 1'b1;
    r.rate = scale_rate(nc - oc, nt - ot);
    return r;
  endfunction

  // Apply one accepted request to the local rings.
  function automatic void absorb(request_t rq);
    int unsigned h;
    if (rq.kind == REQ_PUSH) begin
      h = head_pos[rq.ch];
      count_ring[rq.ch][h] = rq.cnt;
      time_ring[rq.ch][h]  = rq.ts;
      head_pos[rq.ch] = (h + 1 == DEPTH) ? 0 : h + 1;
      n_push++;
    end else begin
      pending_rates.push_back(window_rate(rq.ch, rq.now, rq.win));
      n_query++;
    end
  endfunction

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Random idling, with a quiet stretch where neither side idles.
  function automatic bit idle_now();
    if (quiet_side) return 0;
    return $urandom_range(99) < 21;
  endfunction

  // Result side: random stalls and in-order comparison.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_rates.size() == 0) begin
          $error("result with no query outstanding");
          fail_count++;
        end else begin
          rate_t w;
          w = pending_rates.pop_front();
          n_checked++;
          if (w.ok) n_valid++;
          if (res_ch.rate_valid !== w.ok) begin
            $error("rate_valid: expected %0d, actual %0d", w.ok, res_ch.rate_valid);
            fail_count++;
          end
          if (res_ch.rate !== w.rate) begin
            $error("rate: expected %0h, actual %0h", w.rate, res_ch.rate);
            fail_count++;
          end
        end
      end
      res_ch.ready <= !idle_now();
    end
  end

  // Send one request and wait for its handshake; valid stays high after
  // the handshake until the next call or the caller drops it.
  task automatic send(request_t rq);
    while (idle_now()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rq.kind;
    req_ch.channel      <= rq.ch;
    req_ch.sample_count <= rq.cnt;
    req_ch.sample_time  <= rq.ts;
    req_ch.now_time     <= rq.now;
    req_ch.window_ms    <= rq.win;
    do @(posedge clk); while (!req_ch.ready);
    absorb(rq);
  endtask

  function automatic request_t mk(req_type_t k, int unsigned ch, logic [63:0] c,
                                  logic [63:0] t, logic [63:0] n, logic [31:0] w);
    request_t rq;
    rq.kind = k; rq.ch = CH_W'(ch); rq.cnt = c; rq.ts = t; rq.now = n; rq.win = w;
    return rq;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  row_t rows [$];
  rate_t none_valid;

  // Per-channel running counters for well-formed sample streams.
  logic [63:0] run_cnt [NCH];
  logic [63:0] run_ts  [NCH];

  initial begin
    request_t rq;
    int unsigned ch, sel;
    fail_count = 0; n_push = 0; n_query = 0; n_valid = 0; n_checked = 0;
    cycle_count = 0;
    quiet_side = 0;
    for (int c = 0; c < NCH; c++) begin
      head_pos[c] = 0;
      run_cnt[c] = 0;
      run_ts[c] = 1;
      for (int i = 0; i < DEPTH; i++) begin
        count_ring[c][i] = 0;
        time_ring[c][i] = 0;
      end
    end
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PUSH;
    req_ch.channel = '0;
    req_ch.sample_count = '0;
    req_ch.sample_time = '0;
    req_ch.now_time = '0;
    req_ch.window_ms = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    none_valid.ok = 1'b0;
    none_valid.rate = '0;

    // Directed table: empty ring, extremes, zero timestamps, saturation.
    rows.push_back('{mk(REQ_QUERY, 0, 0, 0, '1, '1), 1, none_valid});
    rows.push_back('{mk(REQ_QUERY, 3, 0, 0, 0, 0), 1, none_valid});
    rows.push_back('{mk(REQ_PUSH, 0, 100, 1000, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 0, 200, 2000, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 0, 1200, 3000, 0, 0), 0, none_valid});
    // Newest 3000, oldest in window 2000, sample at 1000 is outside.
    rows.push_back('{mk(REQ_QUERY, 0, 0, 0, 3000, 1500), 0, none_valid});
    // Window covers everything: no sample outside, invalid.
    rows.push_back('{mk(REQ_QUERY, 0, 0, 0, 3000, 32'hFFFF_FFFF), 1, none_valid});
    // Only the newest is in window: zero span, invalid.
    rows.push_back('{mk(REQ_QUERY, 0, 0, 0, 3000, 0), 1, none_valid});
    // Saturating rate: huge count delta over 1 ms.
    rows.push_back('{mk(REQ_PUSH, 1, 0, 10, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 1, 0, 11, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 1, '1, 12, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_QUERY, 1, 0, 0, 12, 1), 0, none_valid});
    // Zero timestamp push reads as an empty slot and stops the walk.
    rows.push_back('{mk(REQ_PUSH, 2, 5, 50, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 2, 9, 0, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 2, 77, 70, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_QUERY, 2, 0, 0, 70, 0), 1, none_valid});
    // Wrapping timestamps and all-ones fields.
    rows.push_back('{mk(REQ_PUSH, 3, '1, '1, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_PUSH, 3, 3, 5, 0, 0), 0, none_valid});
    rows.push_back('{mk(REQ_QUERY, 3, 0, 0, '1, '1), 0, none_valid});
    rows.push_back('{mk(REQ_QUERY, 3, 0, 0, 0, 0), 0, none_valid});

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        rate_t p;
        p = window_rate(rows[i].rq.ch, rows[i].rq.now, rows[i].rq.win);
        if (p.ok !== rows[i].want.ok || p.rate !== rows[i].want.rate) begin
          $error("directed row %0d: typed rate_valid %0d disagrees with predictor",
                 i, rows[i].want.ok);
          fail_count++;
        end
      end
      send(rows[i].rq);
    end
    req_ch.valid <= 1'b0;

    // Hold off until every directed result is back.
    while (pending_rates.size() != 0) @(posedge clk);

    // Random part: mostly monotonic streams with random content.
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet_side = (n >= 200 && n < 280);
      ch = $urandom_range(NCH - 1);
      sel = $urandom_range(99);
      if (sel < 60) begin
        run_ts[ch] += $urandom_range(1, 50);
        run_cnt[ch] += ($urandom_range(9) == 0) ? rand64() : $urandom_range(5000);
        rq = mk(REQ_PUSH, ch, run_cnt[ch], run_ts[ch], 0, 0);
      end else if (sel < 90) begin
        rq = mk(REQ_QUERY, ch, 0, 0, run_ts[ch] + $urandom_range(20),
                $urandom_range(400));
      end else if (sel < 95) begin
        rq = mk(REQ_PUSH, ch, rand64(), rand64(), 0, 0);
      end else begin
        rq = mk(REQ_QUERY, ch, rand64(), rand64(), rand64(), $urandom());
      end
      send(rq);
    end
    req_ch.valid <= 1'b0;
    quiet_side = 0;

    while (pending_rates.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 100) @(posedge clk);

    $display("Ran %0d pushes and %0d queries; %0d results checked, %0d with a rate.",
             n_push, n_query, n_checked, n_valid);
    if (fail_count == 0 && pending_rates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : windowed_rate_meter_tb
`default_nettype wire
